/* design/mtrd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtrd_pkg
// Types and constants shared by the multithread RV32I decode stage.
// ----------------------------------------------------------------------------
package mtrd_pkg;

  // major opcodes, instruction bits 6..2
  localparam logic [4:0] OPC_LOAD   = 5'd0;
  localparam logic [4:0] OPC_MISC   = 5'd3;
  localparam logic [4:0] OPC_OPIMM  = 5'd4;
  localparam logic [4:0] OPC_AUIPC  = 5'd5;
  localparam logic [4:0] OPC_STORE  = 5'd8;
  localparam logic [4:0] OPC_OP     = 5'd12;
  localparam logic [4:0] OPC_LUI    = 5'd13;
  localparam logic [4:0] OPC_BRANCH = 5'd24;
  localparam logic [4:0] OPC_JALR   = 5'd25;
  localparam logic [4:0] OPC_JAL    = 5'd27;
  localparam logic [4:0] OPC_SYSTEM = 5'd28;

  localparam logic [31:0] WORD_RET = 32'h0000_8067;

  // instruction formats
  localparam logic [2:0] FMT_UNDEF = 3'd0;
  localparam logic [2:0] FMT_R     = 3'd1;
  localparam logic [2:0] FMT_I     = 3'd2;
  localparam logic [2:0] FMT_S     = 3'd3;
  localparam logic [2:0] FMT_B     = 3'd4;
  localparam logic [2:0] FMT_U     = 3'd5;
  localparam logic [2:0] FMT_J     = 3'd6;

  localparam int unsigned MAX_THREADS = 8;

  typedef struct packed {
    logic [2:0] format;
    logic       fetchok;
    logic       nodest;
    logic       ctrl;
    logic       jump;
    logic       rtype;
    logic       system;
    logic       opimm;
    logic       lui;
    logic       ret;
    logic       jalr;
    logic       jal;
    logic       branch;
    logic       store;
    logic       load;
    logic       rs2used;
    logic       rs1used;
  } ctl_t;

  typedef struct packed {
    logic [4:0]         dest_reg;
    logic [4:0]         src1_reg;
    logic [4:0]         src2_reg;
    logic [9:0]         function_code;
    logic [4:0]         major_opcode;
    logic signed [31:0] immediate;
    ctl_t               ctl;
  } dec_t;

  typedef struct packed {
    logic        fetch_valid;
    logic [1:0]  fetch_thread;
    logic [15:0] fetch_pc;
    logic [31:0] fetch_word;
    logic [3:0]  issue_full_mask;
  } in_t;

  typedef struct packed {
    logic               issue_valid;
    logic [1:0]         chosen_thread;
    logic [15:0]        chosen_pc;
    logic [15:0]        next_fetch_pc;
    logic [4:0]         dest_reg;
    logic [4:0]         src1_reg;
    logic [4:0]         src2_reg;
    logic [9:0]         function_code;
    logic [4:0]         major_opcode;
    logic signed [31:0] immediate;
    logic [18:0]        control_bits;
    logic [3:0]         slot_full_mask;
  } out_t;

endpackage

/* design/mtrd_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtrd_decoder
// RV32I field extraction, format classification, immediate and control bits.
// ----------------------------------------------------------------------------
module mtrd_decoder (
  input  logic [31:0]   word_i,
  output mtrd_pkg::dec_t dec_o
);
  import mtrd_pkg::*;

  logic [4:0]  opc;
  logic [4:0]  rd;
  logic [4:0]  rs1;
  logic [4:0]  rs2;
  logic [2:0]  fmt;
  logic [31:0] imm;
  ctl_t        ctl;

  assign opc = word_i[6:2];
  assign rd  = word_i[11:7];
  assign rs1 = word_i[19:15];
  assign rs2 = word_i[24:20];

  always_comb begin
    unique case (opc)
      OPC_LOAD, OPC_MISC, OPC_OPIMM, OPC_JALR, OPC_SYSTEM: fmt = FMT_I;
      OPC_AUIPC, OPC_LUI: fmt = FMT_U;
      OPC_STORE:  fmt = FMT_S;
      OPC_OP:     fmt = FMT_R;
      OPC_BRANCH: fmt = FMT_B;
      OPC_JAL:    fmt = FMT_J;
      default:    fmt = FMT_UNDEF;
    endcase
  end

  // b and j immediates stay in half units
  always_comb begin
    unique case (fmt)
      FMT_I:   imm = {{20{word_i[31]}}, word_i[31:20]};
      FMT_S:   imm = {{20{word_i[31]}}, word_i[31:25], word_i[11:7]};
      FMT_B:   imm = {{20{word_i[31]}}, word_i[31], word_i[7], word_i[30:25],
                      word_i[11:8]};
      FMT_U:   imm = {{12{word_i[31]}}, word_i[31:12]};
      FMT_J:   imm = {{12{word_i[31]}}, word_i[31], word_i[19:12], word_i[20],
                      word_i[30:21]};
      default: imm = '0;
    endcase
  end

  always_comb begin
    ctl.load    = (opc == OPC_LOAD);
    ctl.store   = (opc == OPC_STORE);
    ctl.branch  = (opc == OPC_BRANCH);
    ctl.jal     = (opc == OPC_JAL);
    ctl.jalr    = (opc == OPC_JALR);
    ctl.lui     = (opc == OPC_LUI);
    ctl.opimm   = (opc == OPC_OPIMM);
    ctl.system  = (opc == OPC_SYSTEM);
    ctl.rtype   = (fmt == FMT_R);
    ctl.ret     = (word_i == WORD_RET);
    ctl.rs1used = !ctl.jal && !ctl.lui && (opc != OPC_AUIPC) && (rs1 != 5'd0);
    ctl.rs2used = !ctl.opimm && !ctl.load && !ctl.jal && !ctl.jalr && !ctl.lui
                  && (opc != OPC_AUIPC) && (rs2 != 5'd0);
    ctl.jump    = ctl.jal || ctl.jalr;
    ctl.ctrl    = ctl.branch || ctl.jump;
    ctl.nodest  = ctl.branch || ctl.store || (rd == 5'd0);
    ctl.fetchok = !(ctl.branch || ctl.jalr);
    ctl.format  = fmt;
  end

  always_comb begin
    dec_o.dest_reg      = ctl.nodest ? 5'd0 : rd;
    dec_o.src1_reg      = rs1;
    dec_o.src2_reg      = rs2;
    dec_o.function_code = {word_i[31:25], word_i[14:12]};
    dec_o.major_opcode  = opc;
    dec_o.immediate     = imm;
    dec_o.ctl           = ctl;
  end

endmodule

/* design/multithread_riscv_decode_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multithread_riscv_decode_stage
// Per-thread decode slots with lowest-thread-first selection and RV32I decode.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while in_stall_o is low and returns exactly
// one result transaction for each, through the s1 registers and the output
// register. In the accept cycle the lowest free thread with a full slot is
// picked from the full flags and the slot memory (pc and word, one entry per
// thread) is read at that thread; the delivered fetch is written into its
// thread's entry at the same edge, after the read. The read word is then
// decoded into the output register. Throughput is one transaction per cycle
// while the output is not stalled; the slot memory has a single read port and
// a single write port. Full flags are cleared by reset; slot contents need no
// clearing since a read entry is only used when its flag was set.
module multithread_riscv_decode_stage #(
  parameter int unsigned THREAD_COUNT   = 4,
  parameter int unsigned CODE_ADDR_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mtrd_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mtrd_pkg::out_t out_data_o
);
  import mtrd_pkg::*;

  localparam int unsigned TW     = $clog2(THREAD_COUNT);
  localparam int unsigned SLOT_W = CODE_ADDR_BITS + 32;

  logic [SLOT_W-1:0]       slot_mem [THREAD_COUNT];
  logic [SLOT_W-1:0]       rd_q;

  logic [THREAD_COUNT-1:0] slot_full_q, slot_full_d;
  logic                    s1_valid_q, s1_found_q;
  logic [TW-1:0]           s1_pick_q;
  logic [3:0]              s1_mask_q;
  logic                    out_valid_q;
  out_t                    out_q, out_d;

  logic                    out_ready, s1_ready, acc;
  logic [MAX_THREADS-1:0]  busy;
  logic [MAX_THREADS-1:0]  full_ext;
  logic                    found;
  logic [TW-1:0]           pick;
  logic                    wr_en;
  logic [TW-1:0]           wr_idx;

  logic [31:0]               word;
  logic [CODE_ADDR_BITS-1:0] pc;
  logic [32:0]               imm2;
  logic [CODE_ADDR_BITS-1:0] pc_add;
  logic [CODE_ADDR_BITS-1:0] pc_sum;
  dec_t                      dec;

  // handshake
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_ready   = !s1_valid_q || out_ready;
  assign acc        = in_valid_i && s1_ready;
  assign in_stall_o = !s1_ready;

  // selection
  assign busy = MAX_THREADS'(in_data_i.issue_full_mask);

  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int t = 0; t < THREAD_COUNT; t++) begin
      if (!found && slot_full_q[t] && !busy[t]) begin
        found = 1'b1;
        pick  = TW'(t);
      end
    end
  end

  assign wr_en  = in_data_i.fetch_valid
                  && (32'(in_data_i.fetch_thread) < 32'(THREAD_COUNT));
  assign wr_idx = TW'(in_data_i.fetch_thread);

  always_comb begin
    slot_full_d = slot_full_q;
    if (found) begin
      slot_full_d[pick] = 1'b0;
    end
    if (wr_en) begin
      slot_full_d[wr_idx] = 1'b1;
    end
  end

  assign full_ext = MAX_THREADS'(slot_full_d);

  // slot memory: read before write at the same edge
  always_ff @(posedge clk_i) begin
    if (acc) begin
      rd_q <= slot_mem[pick];
    end
    if (acc && wr_en) begin
      slot_mem[wr_idx] <= {CODE_ADDR_BITS'(in_data_i.fetch_pc), in_data_i.fetch_word};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_full_q <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        slot_full_q <= slot_full_d;
      end
      if (s1_ready) begin
        s1_valid_q <= acc;
      end
      if (out_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_found_q <= found;
      s1_pick_q  <= pick;
      s1_mask_q  <= full_ext[3:0];
    end
    if (out_ready && s1_valid_q) begin
      out_q <= out_d;
    end
  end

  // decode
  assign word = rd_q[31:0];
  assign pc   = rd_q[SLOT_W-1:32];

  mtrd_decoder u_decoder (
    .word_i (word),
    .dec_o  (dec)
  );

  assign imm2   = {dec.immediate, 1'b0};
  assign pc_add = dec.ctl.jal ? CODE_ADDR_BITS'(imm2) : CODE_ADDR_BITS'(4);
  assign pc_sum = pc + pc_add;

  always_comb begin
    out_d                = '0;
    out_d.slot_full_mask = s1_mask_q;
    if (s1_found_q) begin
      out_d.issue_valid   = 1'b1;
      out_d.chosen_thread = 2'(s1_pick_q);
      out_d.chosen_pc     = 16'(pc);
      out_d.next_fetch_pc = 16'(pc_sum);
      out_d.dest_reg      = dec.dest_reg;
      out_d.src1_reg      = dec.src1_reg;
      out_d.src2_reg      = dec.src2_reg;
      out_d.function_code = dec.function_code;
      out_d.major_opcode  = dec.major_opcode;
      out_d.immediate     = dec.immediate;
      out_d.control_bits  = dec.ctl;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  a_pick_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && found && !(wr_en && (wr_idx == pick)) |=> !slot_full_q[$past(pick)])
    else $error("chosen slot not freed");

  a_fetch_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && wr_en |=> slot_full_q[$past(wr_idx)])
    else $error("fetched slot not marked full");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.issue_valid |->
      (out_data_o.immediate == 32'sd0) && (out_data_o.control_bits == 19'd0))
    else $error("fields set without a decode");

endmodule
